// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent, idle during reset
`define MVA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent, idle during reset
`define MVA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/mva_pkg.sv -----
package mva_pkg;

   // Field widths
   localparam int KEY_W    = 7;
   localparam int VEL_W    = 7;
   localparam int OP_W     = 2;
   localparam int IVOICE_W = 3;
   localparam int VOICE_W  = 3;
   localparam int INC_W    = 34;
   localparam int LEVEL_W  = 16;
   localparam int SCALE_W  = 20;
   localparam int ROM_W    = 14;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // Defaults and limits
   localparam int VOICE_COUNT_DEF = 8;
   localparam int MAX_RESULTS     = 8;
   localparam int REPORT_W        = 4;
   localparam int VEL_SHIFT       = 9;
   localparam logic [LEVEL_W-1:0] ENV_MAX_RESET   = 16'hFFFF;
   localparam logic [SCALE_W-1:0] INC_SCALE_RESET = 20'd500000;

   // Operation codes
   localparam logic [OP_W-1:0] OP_NOTE_ON    = 2'd0;
   localparam logic [OP_W-1:0] OP_NOTE_OFF   = 2'd1;
   localparam logic [OP_W-1:0] OP_VOICE_IDLE = 2'd2;

   // Result action codes
   localparam logic ACT_START   = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENV_MAX   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INC_SCALE = 2'd1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_FINISH
   } state_type;

   // Write controls from the sequencer to the voice store
   typedef struct packed {
      logic wr_key;
      logic wr_level;
      logic set_busy;
      logic clr_busy;
   } wr_ctl_type;

   // Pitch table, one entry per MIDI key
   localparam logic [ROM_W-1:0] PITCH_ROM [128] = '{
      14'd8, 14'd9, 14'd9, 14'd10, 14'd10, 14'd11, 14'd12, 14'd12,
      14'd13, 14'd14, 14'd15, 14'd15, 14'd16, 14'd17, 14'd18, 14'd19,
      14'd21, 14'd22, 14'd23, 14'd24, 14'd26, 14'd28, 14'd29, 14'd31,
      14'd33, 14'd35, 14'd37, 14'd39, 14'd41, 14'd44, 14'd46, 14'd49,
      14'd52, 14'd55, 14'd58, 14'd62, 14'd65, 14'd69, 14'd73, 14'd78,
      14'd82, 14'd87, 14'd92, 14'd98, 14'd104, 14'd110, 14'd117, 14'd123,
      14'd131, 14'd139, 14'd147, 14'd156, 14'd165, 14'd175, 14'd185, 14'd196,
      14'd208, 14'd220, 14'd233, 14'd247, 14'd262, 14'd277, 14'd294, 14'd311,
      14'd330, 14'd349, 14'd370, 14'd392, 14'd415, 14'd440, 14'd466, 14'd494,
      14'd523, 14'd554, 14'd587, 14'd622, 14'd659, 14'd698, 14'd740, 14'd784,
      14'd831, 14'd880, 14'd932, 14'd988, 14'd1047, 14'd1109, 14'd1175, 14'd1245,
      14'd1319, 14'd1397, 14'd1480, 14'd1568, 14'd1661, 14'd1760, 14'd1865,
      14'd1976,
      14'd2093, 14'd2217, 14'd2349, 14'd2489, 14'd2637, 14'd2794, 14'd2960,
      14'd3136,
      14'd3322, 14'd3520, 14'd3729, 14'd3951, 14'd4186, 14'd4435, 14'd4699,
      14'd4978,
      14'd5274, 14'd5588, 14'd5920, 14'd6272, 14'd6645, 14'd7040, 14'd7459,
      14'd7902,
      14'd8372, 14'd8870, 14'd9397, 14'd9956, 14'd10548, 14'd11175, 14'd11840,
      14'd12544
   };

   function automatic logic [ROM_W-1:0] pitch_lookup(input logic [KEY_W-1:0] key);
      return PITCH_ROM[key];
   endfunction

endpackage

// ----- hw/rtl/mva_channels.sv -----
// Note event channel
interface mva_req_if;
   import mva_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [KEY_W-1:0]    key;
   logic [VEL_W-1:0]    velocity;
   logic [IVOICE_W-1:0] idle_voice;
   modport source (output valid, op, key, velocity, idle_voice, input ready);
   modport sink   (input valid, op, key, velocity, idle_voice, output ready);
endinterface

// Voice result channel
interface mva_rsp_if;
   import mva_pkg::*;
   logic               valid;
   logic               ready;
   logic               hit;
   logic               action;
   logic [VOICE_W-1:0] voice;
   logic [KEY_W-1:0]   note;
   logic [INC_W-1:0]   phase_increment;
   logic [LEVEL_W-1:0] level;
   logic               last;
   modport source (output valid, hit, action, voice, note, phase_increment, level, last,
                   input ready);
   modport sink   (input valid, hit, action, voice, note, phase_increment, level, last,
                   output ready);
endinterface

// Register write channel
interface mva_csr_if;
   import mva_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/midi_voice_allocator.sv -----
// Channel   Port      Dir  Carries
// -------   -------   ---  ----------------------------------------------
// request   req_bus   in   op, key, velocity, idle_voice
// result    rsp_bus   out  hit, action, voice, note, phase_increment, level, last
// config    csr_bus   in   index, data (0 attack level clamp, 1 increment scale)
//
// Note-on and note-off walk every voice in turn: the sequencer reads and
// compares one voice per read/check pair through the single registered
// key/level read port, then finishes with one multiply. Voice-idle and
// unused ops are handled in the idle state. Result stalls hold the scan only
// when a release or the final result finds the output register still full.
// Reset is synchronous and resets voice valid/busy, state, result valid and config.
module midi_voice_allocator #(
   parameter int VOICE_COUNT = mva_pkg::VOICE_COUNT_DEF
) (
   input logic         clock,
   input logic         reset,
   mva_req_if.sink     req_bus,
   mva_rsp_if.source   rsp_bus,
   mva_csr_if.sink     csr_bus
);
   import mva_pkg::*;

   localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

   logic [LEVEL_W-1:0] env_max_ff, env_max_in;
   logic [SCALE_W-1:0] inc_scale_ff, inc_scale_in;

   wr_ctl_type          ctl;
   logic [VIDX_W-1:0]   wr_addr;
   logic [KEY_W-1:0]    wr_key;
   logic [LEVEL_W-1:0]  wr_level;
   logic [VIDX_W-1:0]   clr_addr;
   logic                rd_en;
   logic [VIDX_W-1:0]   rd_addr;
   logic [KEY_W-1:0]    rd_key;
   logic [LEVEL_W-1:0]  rd_level;
   logic [VOICE_COUNT-1:0] busy;

   // Configuration writes; unknown indexes are dropped
   assign csr_bus.ready = 1'b1;

   always_comb begin
      env_max_in   = env_max_ff;
      inc_scale_in = inc_scale_ff;
      if (csr_bus.valid) begin
         if (csr_bus.index == CSR_ENV_MAX) begin
            env_max_in = csr_bus.data[LEVEL_W-1:0];
         end else if (csr_bus.index == CSR_INC_SCALE) begin
            inc_scale_in = csr_bus.data[SCALE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_max_ff   <= ENV_MAX_RESET;
         inc_scale_ff <= INC_SCALE_RESET;
      end else begin
         env_max_ff   <= env_max_in;
         inc_scale_ff <= inc_scale_in;
      end
   end

   mva_scan_ctrl #(
      .VOICE_COUNT (VOICE_COUNT),
      .VIDX_W      (VIDX_W)
   ) u_scan_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .env_max   (env_max_ff),
      .inc_scale (inc_scale_ff),
      .ctl       (ctl),
      .wr_addr   (wr_addr),
      .wr_key    (wr_key),
      .wr_level  (wr_level),
      .clr_addr  (clr_addr),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_key    (rd_key),
      .rd_level  (rd_level),
      .busy      (busy)
   );

   mva_voice_store #(
      .VOICE_COUNT (VOICE_COUNT),
      .VIDX_W      (VIDX_W)
   ) u_voice_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .wr_addr  (wr_addr),
      .wr_key   (wr_key),
      .wr_level (wr_level),
      .clr_addr (clr_addr),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_key   (rd_key),
      .rd_level (rd_level),
      .busy     (busy)
   );

endmodule

// ----- hw/rtl/mva_voice_store.sv -----
module mva_voice_store #(
   parameter int VOICE_COUNT = mva_pkg::VOICE_COUNT_DEF,
   parameter int VIDX_W      = 3
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mva_pkg::wr_ctl_type         ctl,
   input  logic [VIDX_W-1:0]           wr_addr,
   input  logic [mva_pkg::KEY_W-1:0]   wr_key,
   input  logic [mva_pkg::LEVEL_W-1:0] wr_level,
   input  logic [VIDX_W-1:0]           clr_addr,
   input  logic                        rd_en,
   input  logic [VIDX_W-1:0]           rd_addr,
   output logic [mva_pkg::KEY_W-1:0]   rd_key,
   output logic [mva_pkg::LEVEL_W-1:0] rd_level,
   output logic [VOICE_COUNT-1:0]      busy
);
   import mva_pkg::*;

   logic [KEY_W-1:0]   key_mem   [VOICE_COUNT];
   logic [LEVEL_W-1:0] level_mem [VOICE_COUNT];
   logic [VOICE_COUNT-1:0] valid_ff, valid_in;
   logic [VOICE_COUNT-1:0] busy_ff, busy_in;
   logic [KEY_W-1:0]   rd_key_ff;
   logic [LEVEL_W-1:0] rd_level_ff;

   // Mark voices assigned and busy; drop busy on an idle event
   always_comb begin
      valid_in = valid_ff;
      busy_in  = busy_ff;
      if (ctl.wr_level) begin
         valid_in[wr_addr] = 1'b1;
      end
      if (ctl.set_busy) begin
         busy_in[wr_addr] = 1'b1;
      end
      if (ctl.clr_busy) begin
         busy_in[clr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         busy_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         busy_ff  <= busy_in;
      end
   end

   // Write key and level entries
   always_ff @(posedge clock) begin
      if (ctl.wr_key) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (ctl.wr_level) begin
         level_mem[wr_addr] <= wr_level;
      end
   end

   // Registered read; an unassigned voice reads as key 0, level 0
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff   <= valid_ff[rd_addr] ? key_mem[rd_addr] : '0;
         rd_level_ff <= valid_ff[rd_addr] ? level_mem[rd_addr] : '0;
      end
   end

   assign rd_key   = rd_key_ff;
   assign rd_level = rd_level_ff;
   assign busy     = busy_ff;

endmodule

// ----- hw/rtl/mva_scan_ctrl.sv -----
module mva_scan_ctrl #(
   parameter int VOICE_COUNT = mva_pkg::VOICE_COUNT_DEF,
   parameter int VIDX_W      = 3
) (
   input  logic                        clock,
   input  logic                        reset,
   mva_req_if.sink                     req_bus,
   mva_rsp_if.source                   rsp_bus,
   input  logic [mva_pkg::LEVEL_W-1:0] env_max,
   input  logic [mva_pkg::SCALE_W-1:0] inc_scale,
   output mva_pkg::wr_ctl_type         ctl,
   output logic [VIDX_W-1:0]           wr_addr,
   output logic [mva_pkg::KEY_W-1:0]   wr_key,
   output logic [mva_pkg::LEVEL_W-1:0] wr_level,
   output logic [VIDX_W-1:0]           clr_addr,
   output logic                        rd_en,
   output logic [VIDX_W-1:0]           rd_addr,
   input  logic [mva_pkg::KEY_W-1:0]   rd_key,
   input  logic [mva_pkg::LEVEL_W-1:0] rd_level,
   input  logic [VOICE_COUNT-1:0]      busy
);
   import mva_pkg::*;

   localparam logic [VIDX_W-1:0]   LAST_IDX = VIDX_W'(VOICE_COUNT - 1);
   localparam logic [REPORT_W-1:0] REPORT_FULL = REPORT_W'(MAX_RESULTS);

   state_type state_ff, state_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic [VIDX_W-1:0]   idx_ff, idx_in;
   logic                found_ff, found_in;
   logic [VIDX_W-1:0]   found_idx_ff, found_idx_in;
   logic                free_ff, free_in;
   logic [VIDX_W-1:0]   free_idx_ff, free_idx_in;
   logic                pend_ff, pend_in;
   logic [VIDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic [LEVEL_W-1:0]  pend_level_ff, pend_level_in;
   logic [REPORT_W-1:0] count_ff, count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic               rsp_action_ff, rsp_action_in;
   logic [VOICE_W-1:0] rsp_voice_ff, rsp_voice_in;
   logic [KEY_W-1:0]   rsp_note_ff, rsp_note_in;
   logic [INC_W-1:0]   rsp_inc_ff, rsp_inc_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [LEVEL_W-1:0] vel_level;
   logic [INC_W-1:0]   inc_prod;
   logic [VIDX_W-1:0]  sel_idx;
   logic               out_free;
   logic               match;
   logic               step_done;
   logic               idle_in_range;

   // Shared key comparator, one voice per check cycle
   assign match = (rd_key == key_ff);

   assign vel_level     = {req_bus.velocity, VEL_SHIFT'(0)};
   assign inc_prod      = inc_scale * pitch_lookup(key_ff);
   assign sel_idx       = found_ff ? found_idx_ff : free_idx_ff;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign idle_in_range = ({29'd0, req_bus.idle_voice} < 32'(VOICE_COUNT));

   // Sequencer: accept, scan one voice per read/check pair, finish
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      level_in      = level_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      pend_level_in = pend_level_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_action_in = rsp_action_ff;
      rsp_voice_in  = rsp_voice_ff;
      rsp_note_in   = rsp_note_ff;
      rsp_inc_in    = rsp_inc_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_last_in   = rsp_last_ff;
      ctl           = '0;
      wr_addr       = idx_ff;
      wr_key        = '0;
      wr_level      = level_ff;
      clr_addr      = VIDX_W'(req_bus.idle_voice);
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      req_bus.ready = 1'b0;
      step_done     = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               op_in    = req_bus.op;
               key_in   = req_bus.key;
               level_in = (vel_level > env_max) ? env_max : vel_level;
               idx_in   = '0;
               found_in = 1'b0;
               free_in  = 1'b0;
               pend_in  = 1'b0;
               count_in = '0;
               if (req_bus.op == OP_NOTE_ON || req_bus.op == OP_NOTE_OFF) begin
                  state_in = ST_READ;
               end else if (req_bus.op == OP_VOICE_IDLE) begin
                  ctl.clr_busy = idle_in_range;
               end
            end
         end

         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_CHECK;
         end

         ST_CHECK: begin
            if (op_ff == OP_NOTE_ON) begin
               // Keep the lowest key match and the lowest idle voice
               if (match && !found_ff) begin
                  found_in     = 1'b1;
                  found_idx_in = idx_ff;
               end
               if (!busy[idx_ff] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = idx_ff;
               end
            end else if (match) begin
               // Release: clear the key, report up to the result limit
               if (count_ff == REPORT_FULL) begin
                  ctl.wr_key = 1'b1;
               end else if (pend_ff && !out_free) begin
                  step_done = 1'b0;
               end else begin
                  ctl.wr_key = 1'b1;
                  if (pend_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_hit_in    = 1'b1;
                     rsp_action_in = ACT_RELEASE;
                     rsp_voice_in  = VOICE_W'(pend_idx_ff);
                     rsp_note_in   = key_ff;
                     rsp_inc_in    = '0;
                     rsp_level_in  = pend_level_ff;
                     rsp_last_in   = 1'b0;
                  end
                  pend_in       = 1'b1;
                  pend_idx_in   = idx_ff;
                  pend_level_in = rd_level;
                  count_in      = count_ff + REPORT_W'(1);
               end
            end
            if (step_done) begin
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_FINISH;
               end else begin
                  idx_in   = idx_ff + VIDX_W'(1);
                  state_in = ST_READ;
               end
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_note_in  = key_ff;
               rsp_last_in  = 1'b1;
               rsp_hit_in   = 1'b0;
               rsp_voice_in = '0;
               rsp_inc_in   = '0;
               rsp_level_in = '0;
               if (op_ff == OP_NOTE_ON) begin
                  rsp_action_in = ACT_START;
                  if (found_ff || free_ff) begin
                     rsp_hit_in    = 1'b1;
                     rsp_voice_in  = VOICE_W'(sel_idx);
                     rsp_inc_in    = inc_prod;
                     rsp_level_in  = level_ff;
                     ctl.wr_key    = 1'b1;
                     ctl.wr_level  = 1'b1;
                     ctl.set_busy  = 1'b1;
                     wr_addr       = sel_idx;
                     wr_key        = key_ff;
                  end
               end else begin
                  rsp_action_in = ACT_RELEASE;
                  if (pend_ff) begin
                     rsp_hit_in   = 1'b1;
                     rsp_voice_in = VOICE_W'(pend_idx_ff);
                     rsp_level_in = pend_level_ff;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      level_ff      <= level_in;
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      pend_ff       <= pend_in;
      pend_idx_ff   <= pend_idx_in;
      pend_level_ff <= pend_level_in;
      count_ff      <= count_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_action_ff <= rsp_action_in;
      rsp_voice_ff  <= rsp_voice_in;
      rsp_note_ff   <= rsp_note_in;
      rsp_inc_ff    <= rsp_inc_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.hit             = rsp_hit_ff;
   assign rsp_bus.action          = rsp_action_ff;
   assign rsp_bus.voice           = rsp_voice_ff;
   assign rsp_bus.note            = rsp_note_ff;
   assign rsp_bus.phase_increment = rsp_inc_ff;
   assign rsp_bus.level           = rsp_level_ff;
   assign rsp_bus.last            = rsp_last_ff;

endmodule

// ----- hw/rtl/mva_checker.sv -----
`include "assert_macros.svh"

module mva_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [mva_pkg::OP_W-1:0]    req_op,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_hit,
   input logic                        rsp_action,
   input logic [mva_pkg::INC_W-1:0]   rsp_inc,
   input logic [mva_pkg::LEVEL_W-1:0] rsp_level,
   input logic                        rsp_last
);
   import mva_pkg::*;

   // A stalled result item stays offered
   `MVA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result item dropped while stalled")

   // A miss is a single, empty result
   `MVA_ASSERT_NOW(a_miss_empty, clock, reset, rsp_valid && !rsp_hit, rsp_last && rsp_inc == '0 && rsp_level == '0, "miss item not empty or not last")

   // Releases carry no phase increment
   `MVA_ASSERT_NOW(a_release_inc, clock, reset, rsp_valid && rsp_action == ACT_RELEASE, rsp_inc == '0, "release item with phase increment")

   // A note item starts a scan and blocks further input
   `MVA_ASSERT_NEXT(a_scan_busy, clock, reset, req_valid && req_ready && (req_op == OP_NOTE_ON || req_op == OP_NOTE_OFF), !req_ready, "input taken during voice scan")

endmodule

bind midi_voice_allocator mva_checker u_mva_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .req_op     (req_bus.op),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_hit    (rsp_bus.hit),
   .rsp_action (rsp_bus.action),
   .rsp_inc    (rsp_bus.phase_increment),
   .rsp_level  (rsp_bus.level),
   .rsp_last   (rsp_bus.last)
);
